// File: hw/rtl/wdfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdfd_pkg
// Shared types and constants of the word-delta frame decoder.
// ----------------------------------------------------------------------------
package wdfd_pkg;

   localparam int ADDR_BITS   = 20;
   localparam int WIDTH_BITS  = 13;
   localparam int PROD_BITS   = 30;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = 13'd320;

   localparam logic [1:0] KIND_WORD = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_start;
   } req_type;

   typedef struct packed {
      logic [1:0]           write_kind;
      logic [ADDR_BITS-1:0] write_addr;
      logic [15:0]          write_data;
      logic [7:0]           repeat_words;
   } rsp_type;

   // command handed from the parser to the address stage
   typedef struct packed {
      logic [1:0]            kind;
      logic [15:0]           row;
      logic [WIDTH_BITS-1:0] width;
      logic [ADDR_BITS-1:0]  offset;
      logic [15:0]           data;
      logic [7:0]            repeat_words;
   } cmd_type;

endpackage

// File: hw/rtl/wdfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdfd_front
// Byte parser: walks line count, opcodes, packets and data words, and
// produces at most one write command per accepted byte.
// ----------------------------------------------------------------------------
module wdfd_front
   import wdfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  req_type               req_payload,
   input  logic [WIDTH_BITS-1:0] line_width,
   output logic                  cmd_valid,
   output cmd_type               cmd
);

   localparam logic [2:0] PH_LCLO = 3'd0;
   localparam logic [2:0] PH_LCHI = 3'd1;
   localparam logic [2:0] PH_OPLO = 3'd2;
   localparam logic [2:0] PH_OPHI = 3'd3;
   localparam logic [2:0] PH_SKIP = 3'd4;
   localparam logic [2:0] PH_SIZE = 3'd5;
   localparam logic [2:0] PH_DLO  = 3'd6;
   localparam logic [2:0] PH_DHI  = 3'd7;

   logic [2:0]            phase_ff,     phase_in;
   logic [15:0]           lines_ff,     lines_in;
   logic [15:0]           packets_ff,   packets_in;
   logic [15:0]           row_ff,       row_in;
   logic [15:0]           pkt_row_ff,   pkt_row_in;
   logic [WIDTH_BITS-1:0] pkt_width_ff, pkt_width_in;
   logic [ADDR_BITS-1:0]  offset_ff,    offset_in;
   logic [7:0]            run_ff,       run_in;
   logic                  rep_ff,       rep_in;
   logic [7:0]            hold_ff,      hold_in;

   logic [2:0]           cur_phase;
   logic [15:0]          cur_lines;
   logic [15:0]          cur_packets;
   logic [15:0]          cur_row;
   logic [15:0]          cur_pkt_row;
   logic [ADDR_BITS-1:0] cur_offset;
   logic [7:0]           cur_run;
   logic                 cur_rep;
   logic [7:0]           b;
   logic [15:0]          word;
   logic [15:0]          pk_dec;
   logic [15:0]          ln_dec;
   logic [7:0]           run_dec;
   logic                 done;

   always_comb begin
      b           = req_payload.data_byte;
      cur_phase   = req_payload.chunk_start ? PH_LCLO : phase_ff;
      cur_lines   = req_payload.chunk_start ? 16'd0 : lines_ff;
      cur_packets = req_payload.chunk_start ? 16'd0 : packets_ff;
      cur_row     = req_payload.chunk_start ? 16'd0 : row_ff;
      cur_pkt_row = req_payload.chunk_start ? 16'd0 : pkt_row_ff;
      cur_offset  = req_payload.chunk_start ? '0 : offset_ff;
      cur_run     = req_payload.chunk_start ? 8'd0 : run_ff;
      cur_rep     = req_payload.chunk_start ? 1'b0 : rep_ff;
      word        = {b, hold_ff};
      pk_dec      = cur_packets - 16'd1;
      ln_dec      = cur_lines - 16'd1;
      run_dec     = cur_run - 8'd1;

      phase_in     = cur_phase;
      lines_in     = cur_lines;
      packets_in   = cur_packets;
      row_in       = cur_row;
      pkt_row_in   = cur_pkt_row;
      pkt_width_in = pkt_width_ff;
      offset_in    = cur_offset;
      run_in       = cur_run;
      rep_in       = cur_rep;
      hold_in      = hold_ff;
      done         = 1'b0;

      cmd_valid         = 1'b0;
      cmd.kind          = KIND_WORD;
      cmd.row           = cur_pkt_row;
      cmd.width         = pkt_width_ff;
      cmd.offset        = cur_offset;
      cmd.data          = word;
      cmd.repeat_words  = 8'd1;

      case (cur_phase)
         PH_LCLO: begin
            hold_in  = b;
            phase_in = PH_LCHI;
         end
         PH_LCHI: begin
            lines_in = word;
            phase_in = PH_OPLO;
            done     = (word == 16'd0);
         end
         PH_OPLO: begin
            if (cur_lines != 16'd0) begin
               hold_in  = b;
               phase_in = PH_OPHI;
            end
         end
         PH_OPHI: begin
            if (word[15]) begin
               phase_in = PH_OPLO;
               if (word[14]) begin
                  row_in = cur_row - word;
               end else begin
                  cmd_valid  = 1'b1;
                  cmd.kind   = KIND_BYTE;
                  cmd.row    = cur_row + 16'd1;
                  cmd.width  = line_width;
                  cmd.offset = '1;
                  cmd.data   = {8'd0, word[7:0]};
               end
            end else begin
               pkt_row_in   = cur_row;
               pkt_width_in = line_width;
               offset_in    = '0;
               row_in       = cur_row + 16'd1;
               packets_in   = word;
               if (word == 16'd0) begin
                  phase_in = PH_OPLO;
                  lines_in = ln_dec;
                  done     = (ln_dec == 16'd0);
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            offset_in = cur_offset + ADDR_BITS'(b);
            phase_in  = PH_SIZE;
         end
         PH_SIZE: begin
            if (b[7]) begin
               run_in   = 8'd0 - b;
               rep_in   = 1'b1;
               phase_in = PH_DLO;
            end else if (b == 8'd0) begin
               packets_in = pk_dec;
               if (pk_dec == 16'd0) begin
                  phase_in = PH_OPLO;
                  lines_in = ln_dec;
                  done     = (ln_dec == 16'd0);
               end else begin
                  phase_in = PH_SKIP;
               end
            end else begin
               run_in   = b;
               rep_in   = 1'b0;
               phase_in = PH_DLO;
            end
         end
         PH_DLO: begin
            hold_in  = b;
            phase_in = PH_DHI;
         end
         PH_DHI: begin
            cmd_valid = 1'b1;
            if (cur_rep) begin
               cmd.repeat_words = cur_run;
               offset_in = cur_offset + ADDR_BITS'({cur_run, 1'b0});
               run_in    = 8'd0;
            end else begin
               offset_in = cur_offset + ADDR_BITS'(2);
               run_in    = run_dec;
            end
            if (cur_rep || (run_dec == 8'd0)) begin
               packets_in = pk_dec;
               if (pk_dec == 16'd0) begin
                  phase_in = PH_OPLO;
                  lines_in = ln_dec;
               end else begin
                  phase_in = PH_SKIP;
               end
            end else begin
               phase_in = PH_DLO;
            end
         end
         default: begin
            phase_in = PH_LCLO;
         end
      endcase

      if (done) begin
         cmd_valid        = 1'b1;
         cmd.kind         = KIND_DONE;
         cmd.row          = 16'd0;
         cmd.width        = '0;
         cmd.offset       = '0;
         cmd.data         = 16'd0;
         cmd.repeat_words = 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LCLO;
         lines_ff     <= 16'd0;
         packets_ff   <= 16'd0;
         row_ff       <= 16'd0;
         pkt_row_ff   <= 16'd0;
         pkt_width_ff <= LINE_WIDTH_RESET;
         offset_ff    <= '0;
         run_ff       <= 8'd0;
         rep_ff       <= 1'b0;
         hold_ff      <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         lines_ff     <= lines_in;
         packets_ff   <= packets_in;
         row_ff       <= row_in;
         pkt_row_ff   <= pkt_row_in;
         pkt_width_ff <= pkt_width_in;
         offset_ff    <= offset_in;
         run_ff       <= run_in;
         rep_ff       <= rep_in;
         hold_ff      <= hold_in;
      end
   end

endmodule

// File: hw/rtl/wdfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdfd_queue
// Small command queue between the parser and the address stage.
// ----------------------------------------------------------------------------
module wdfd_queue
   import wdfd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   cmd_type             mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hw/rtl/wdfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdfd_back
// Address stage: row times line width, then pointer add into the output
// register. Holds the line width register.
// ----------------------------------------------------------------------------
module wdfd_back
   import wdfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [WIDTH_BITS-1:0] csr_wr_data,
   output logic [WIDTH_BITS-1:0] line_width,
   input  logic                  head_valid,
   input  cmd_type               head_cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload
);

   logic [WIDTH_BITS-1:0] line_width_ff;
   logic                  a_valid_ff;
   cmd_type               a_cmd_ff;
   logic [ADDR_BITS-1:0]  a_prod_ff;
   logic                  out_valid_ff;
   rsp_type               out_ff;
   logic                  out_adv;
   logic                  a_adv;
   logic signed [PROD_BITS-1:0] prod_full;

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign a_adv     = !a_valid_ff || out_adv;
   assign pop       = a_adv;
   assign prod_full = $signed(head_cmd.row) * $signed({1'b0, head_cmd.width});

   assign line_width  = line_width_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         a_valid_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            line_width_ff <= csr_wr_data;
         end
         if (a_adv) begin
            a_valid_ff <= head_valid;
         end
         if (out_adv) begin
            out_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && head_valid) begin
         a_cmd_ff  <= head_cmd;
         a_prod_ff <= prod_full[ADDR_BITS-1:0];
      end
      if (out_adv && a_valid_ff) begin
         out_ff.write_kind   <= a_cmd_ff.kind;
         out_ff.write_addr   <= a_prod_ff + a_cmd_ff.offset;
         out_ff.write_data   <= a_cmd_ff.data;
         out_ff.repeat_words <= a_cmd_ff.repeat_words;
      end
   end

endmodule

// File: hw/rtl/word_delta_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_delta_frame_decoder_unit
// Decodes a word-oriented delta chunk, one payload byte per transaction on
// req, into frame-buffer write commands and a chunk-done marker on rsp.
// chunk_start on a byte restarts parsing at the line count.
// csr_wr_en/csr_wr_data load the line width (bytes per line, reset 320);
// write it only while the unit is idle.
// Throughput: one byte per cycle unless req_stall is high. Each byte
// gives at most one command; replicated runs come out as a single fill
// command. The parser feeds a command queue; the address stage (row
// times width, then pointer add) registers each command and drains it
// into the rsp output register.
// rsp_stall holds the output register; the queue keeps taking bytes until
// it is full, then req_stall rises.
// Reset (synchronous) empties queue and pipeline and returns the parser to
// the line-count phase.
// ----------------------------------------------------------------------------
module word_delta_frame_decoder_unit
   import wdfd_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [WIDTH_BITS-1:0] csr_wr_data
);

   logic                  accept;
   logic                  cmd_valid;
   cmd_type               cmd;
   logic                  full;
   logic                  head_valid;
   cmd_type               head_cmd;
   logic                  pop;
   logic [WIDTH_BITS-1:0] line_width;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   wdfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .line_width  (line_width),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   wdfd_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && cmd_valid),
      .push_cmd   (cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   wdfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .line_width  (line_width),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: tb/sv/word_delta_frame_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_delta_frame_decoder_unit_tb
// Self-checking bench for the word-delta frame decoder. A scripted chunk
// walks line skips, byte writes, fill and literal packets and the done
// marker. Random well-formed chunks, cut-off chunks and stray bytes then
// follow under several line widths. Every write command is checked,
// against a bench-side decoder or, in the script, against fixed values.
// Both channels idle at random, and the output is held long enough to
// back up the input.
module word_delta_frame_decoder_unit_tb;
   import wdfd_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT = 300000;

   typedef enum logic [2:0] {
      PH_COUNT_LO, PH_COUNT_HI, PH_OP_LO, PH_OP_HI,
      PH_SKIP, PH_SIZE, PH_DATA_LO, PH_DATA_HI
   } parse_phase_type;

   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_TYPED} script_check_type;

   typedef struct {
      logic [7:0]       data;
      logic             start;
      script_check_type check;
      rsp_type          result;
   } script_entry_type;

   localparam rsp_type NO_WRITE  = '0;
   localparam rsp_type DONE_MARK = '{KIND_DONE, 20'd0, 16'd0, 8'd1};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_payload;
   logic                  csr_wr_en;
   logic [WIDTH_BITS-1:0] csr_wr_data;

   // decoder mirror
   logic [WIDTH_BITS-1:0] width_q;
   parse_phase_type       phase;
   logic [15:0]           lines_left;
   logic [15:0]           packets_left;
   logic [15:0]           row_q;
   logic [ADDR_BITS-1:0]  ptr_q;
   logic [7:0]            run_left;
   logic [7:0]            hold_q;
   logic                  run_fill;
   bit                    byte_ignored;

   rsp_type expected_writes [$];
   req_type pending_bytes [$];

   int idle_pct = 23;
   int stall_pct = 23;
   int hold_cycles = 0;
   int items_sent = 0;
   int writes_checked = 0;
   int word_writes = 0;
   int byte_writes = 0;
   int done_marks = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // line count 0, line skip, byte write, fill and literal packets, zero size, zero packets
   script_entry_type chunk_script [25] = '{
      '{8'h00, 1'b1, CHECK_NONE,  NO_WRITE},
      '{8'h00, 1'b0, CHECK_TYPED, DONE_MARK},
      '{8'h55, 1'b0, CHECK_NONE,  NO_WRITE},
      '{8'h03, 1'b1, CHECK_NONE,  NO_WRITE},
      '{8'h00, 1'b0, CHECK_NONE,  NO_WRITE},
      '{8'hFF, 1'b0, CHECK_NONE,  NO_WRITE},
      '{8'h80, 1'b0, CHECK_TYPED, '{KIND_BYTE, 20'd319, 16'h00FF, 8'd1}},
      '{8'hFE, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'hFF, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'h02, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'h00, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'hFF, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'h80, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'hAA, 1'b0, CHECK_NONE,  NO_WRITE},
      '{8'h55, 1'b0, CHECK_TYPED, '{KIND_WORD, 20'd895, 16'h55AA, 8'd128}},
      '{8'h00, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'h01, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'hFF, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'hFF, 1'b0, CHECK_TYPED, '{KIND_WORD, 20'd1151, 16'hFFFF, 8'd1}},
      '{8'h01, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'h00, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'h00, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'h00, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'h00, 1'b0, CHECK_MODEL, NO_WRITE},
      '{8'h00, 1'b0, CHECK_TYPED, DONE_MARK}
   };

   word_delta_frame_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // decoder mirror
   // ------------------------------------------------------------------
   function automatic bit end_line();
      phase = PH_OP_LO;
      lines_left = lines_left - 16'd1;
      return lines_left == 16'd0;
   endfunction

   function automatic bit end_packet();
      packets_left = packets_left - 16'd1;
      if (packets_left == 16'd0) return end_line();
      phase = PH_SKIP;
      return 1'b0;
   endfunction

   // signed row times stride, wrapped to the address width
   function automatic logic [ADDR_BITS-1:0] row_base(input logic [15:0] row);
      longint product;
      product = longint'($signed(row)) * longint'({1'b0, width_q});
      return product[ADDR_BITS-1:0];
   endfunction

   function automatic bit decode_byte(input req_type item, output rsp_type res);
      logic [7:0]  b;
      logic [15:0] word;
      bit          done;
      b = item.data_byte;
      word = {b, hold_q};
      done = 1'b0;
      res = NO_WRITE;
      byte_ignored = 1'b0;
      if (item.chunk_start) begin
         phase = PH_COUNT_LO;
         lines_left = '0;
         packets_left = '0;
         row_q = '0;
         ptr_q = '0;
         run_left = '0;
         run_fill = 1'b0;
      end
      case (phase)
         PH_COUNT_LO: begin
            hold_q = b;
            phase = PH_COUNT_HI;
         end
         PH_COUNT_HI: begin
            lines_left = word;
            phase = PH_OP_LO;
            done = (word == 16'd0);
         end
         PH_OP_LO: begin
            if (lines_left == 16'd0) begin
               byte_ignored = 1'b1;
            end else begin
               hold_q = b;
               phase = PH_OP_HI;
            end
         end
         PH_OP_HI: begin
            if (word[15]) begin
               phase = PH_OP_LO;
               if (word[14]) begin
                  row_q = row_q - word;
               end else begin
                  res = '{KIND_BYTE, row_base(row_q + 16'd1) - 20'd1, {8'h00, word[7:0]}, 8'd1};
                  return 1'b1;
               end
            end else begin
               ptr_q = row_base(row_q);
               row_q = row_q + 16'd1;
               packets_left = word;
               if (word == 16'd0) done = end_line();
               else phase = PH_SKIP;
            end
         end
         PH_SKIP: begin
            ptr_q = ptr_q + b;
            phase = PH_SIZE;
         end
         PH_SIZE: begin
            if (b[7]) begin
               run_left = 8'd0 - b;
               run_fill = 1'b1;
               phase = PH_DATA_LO;
            end else if (b == 8'd0) begin
               done = end_packet();
            end else begin
               run_left = b;
               run_fill = 1'b0;
               phase = PH_DATA_LO;
            end
         end
         PH_DATA_LO: begin
            hold_q = b;
            phase = PH_DATA_HI;
         end
         default: begin
            if (run_fill) begin
               res = '{KIND_WORD, ptr_q, word, run_left};
               ptr_q = ptr_q + {run_left, 1'b0};
               run_left = '0;
               void'(end_packet());
            end else begin
               res = '{KIND_WORD, ptr_q, word, 8'd1};
               ptr_q = ptr_q + 20'd2;
               run_left = run_left - 8'd1;
               if (run_left == 8'd0) void'(end_packet());
               else phase = PH_DATA_LO;
            end
            return 1'b1;
         end
      endcase
      if (done) res = DONE_MARK;
      return done;
   endfunction

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   function automatic void add_byte(input logic [7:0] b, input logic start);
      req_type item;
      item.data_byte = b;
      item.chunk_start = start;
      pending_bytes.push_back(item);
   endfunction

   function automatic void add_word(input logic [15:0] w, input logic start);
      add_byte(w[7:0], start);
      add_byte(w[15:8], 1'b0);
   endfunction

   function automatic void build_chunk();
      int          lines;
      int          packets;
      int          pick;
      int          cut;
      logic [7:0]  size_byte;
      lines = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
      add_word(($urandom_range(19) == 0) ? 16'($urandom) : 16'(lines), 1'b1);
      for (int l = 0; l < lines; l++) begin
         repeat ($urandom_range(0, 2)) begin
            pick = $urandom_range(3);
            if (pick == 0) add_word({2'b11, 14'($urandom)}, 1'b0);
            else if (pick == 1) add_word(16'd0 - 16'($urandom_range(1, 4)), 1'b0);
            else add_word({2'b10, 14'($urandom)}, 1'b0);
         end
         packets = ($urandom_range(39) == 0) ? $urandom_range(16'h4000, 16'h7FFF)
                                             : $urandom_range(0, 3);
         add_word(16'(packets), 1'b0);
         for (int p = 0; p < packets && p < 4; p++) begin
            add_byte(8'($urandom), 1'b0);
            pick = $urandom_range(99);
            if (pick < 35) size_byte = 8'($urandom_range(128, 255));
            else if (pick < 43) size_byte = 8'd0;
            else if (pick < 90) size_byte = 8'($urandom_range(1, 3));
            else if (pick < 98) size_byte = 8'($urandom_range(4, 16));
            else size_byte = 8'd127;
            add_byte(size_byte, 1'b0);
            if (size_byte[7]) add_word(16'($urandom), 1'b0);
            else repeat (size_byte) add_word(16'($urandom), 1'b0);
         end
      end
      // cut-off chunk
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(1, pending_bytes.size());
         while (pending_bytes.size() > cut) void'(pending_bytes.pop_back());
      end
   endfunction

   function automatic void build_noise();
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom), $urandom_range(3) == 0);
   endfunction

   task automatic send_byte(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_payload <= req_type'(9'($urandom));
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic deliver(input req_type item);
      rsp_type res;
      send_byte(item);
      if (decode_byte(item, res)) expected_writes.push_back(res);
      if (!byte_ignored) items_sent++;
   endtask

   task automatic run_traffic(input int count);
      int goal;
      goal = items_sent + count;
      while (items_sent < goal) begin
         if ($urandom_range(99) < 12) build_noise();
         else build_chunk();
         while (pending_bytes.size() != 0) deliver(pending_bytes.pop_front());
      end
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
   endtask

   task automatic load_line_width(input logic [WIDTH_BITS-1:0] w);
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      width_q = w;
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_writes
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         writes_checked++;
         case (rsp_payload.write_kind)
            KIND_WORD: word_writes++;
            KIND_BYTE: byte_writes++;
            default:   done_marks++;
         endcase
         if (expected_writes.size() == 0) begin
            $error("unexpected write command: %p", rsp_payload);
            mismatches++;
         end else begin
            want = expected_writes.pop_front();
            if (rsp_payload.write_kind !== want.write_kind) begin
               $error("write_kind: expected %0d, got %0d", want.write_kind,
                      rsp_payload.write_kind);
               mismatches++;
            end
            if (rsp_payload.write_addr !== want.write_addr) begin
               $error("write_addr: expected 0x%05h, got 0x%05h", want.write_addr,
                      rsp_payload.write_addr);
               mismatches++;
            end
            if (rsp_payload.write_data !== want.write_data) begin
               $error("write_data: expected 0x%04h, got 0x%04h", want.write_data,
                      rsp_payload.write_data);
               mismatches++;
            end
            if (rsp_payload.repeat_words !== want.repeat_words) begin
               $error("repeat_words: expected %0d, got %0d", want.repeat_words,
                      rsp_payload.repeat_words);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : main_sequence
      req_type               item;
      rsp_type               res;
      bit                    has;
      logic [WIDTH_BITS-1:0] mid_width;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      width_q = LINE_WIDTH_RESET;
      phase = PH_COUNT_LO;
      lines_left = '0;
      packets_left = '0;
      row_q = '0;
      ptr_q = '0;
      run_left = '0;
      hold_q = '0;
      run_fill = 1'b0;
      mid_width = 13'($urandom_range(2, 4095));
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // scripted chunk at the reset line width
      foreach (chunk_script[i]) begin
         item.data_byte = chunk_script[i].data;
         item.chunk_start = chunk_script[i].start;
         send_byte(item);
         has = decode_byte(item, res);
         case (chunk_script[i].check)
            CHECK_MODEL: if (has) expected_writes.push_back(res);
            CHECK_TYPED: expected_writes.push_back(chunk_script[i].result);
            default: ;
         endcase
         items_sent++;
      end

      // no idling on either side
      idle_pct = 0;
      stall_pct = 0;
      load_line_width(13'd1);
      run_traffic(150);
      idle_pct = 23;
      stall_pct = 23;

      // long output hold while bytes keep coming
      load_line_width(13'd4096);
      run_traffic(75);
      hold_cycles = 60;
      run_traffic(75);

      // sender waits once for all pending writes, between two traffic runs
      load_line_width(13'd8191);
      run_traffic(75);
      wait_drain();
      run_traffic(75);

      load_line_width(13'd0);
      run_traffic(150);

      load_line_width(mid_width);
      run_traffic(150);

      load_line_width(LINE_WIDTH_RESET);
      run_traffic(150);

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d payload bytes sent, %0d write commands checked (%0d word, %0d byte, %0d done)",
               items_sent, writes_checked, word_writes, byte_writes, done_marks);
      $display("line widths 320, 1, 4096, 8191, 0 and %0d; output hold and full drain exercised",
               mid_width);
      if (mismatches == 0 && expected_writes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
